// ===== src/mse_pkg.sv =====
// Shared types for the merge sort engine: sequencer states and control bundles.
`default_nettype none

package mse_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,    // taking input words into the element memory
        ST_RDA,     // set up a merge group, read left head
        ST_LDA,     // latch left head, read right head
        ST_LDB,     // latch right head
        ST_CMP,     // compare heads, write the smaller one
        ST_LDN,     // latch the refilled head
        ST_OUT_RD,  // read next sorted word when the output is free
        ST_OUT_LD   // load the output register
    } t_state;

    // memory control from the sequencer
    typedef struct packed {
        logic we_elem;   // write the element memory
        logic we_scr;    // write the scratch memory
        logic rd_scr;    // read data comes from the scratch memory
    } t_mem_ctl;

    // output register control from the sequencer
    typedef struct packed {
        logic load;      // load read data into the output register
        logic last;      // that word closes the set
    } t_out_ctl;

endpackage

`default_nettype wire

// ===== src/merge_sort_engine.sv =====
// Top level of the merge sort engine: memories, read mux and output register.
`default_nettype none

// Sorts a set of up to MAX_ITEMS signed words, ascending and stable (on equal
// values the earlier word comes first). Words are loaded one per cycle; the
// set closes on a word with i_last set, or on the word that fills MAX_ITEMS.
// The block then stalls its input and sorts bottom-up: passes of run width
// 1, 2, 4, ... merge adjacent runs, ping-ponging between the element memory
// and a scratch memory, so no copy-back pass is needed. Both memories have a
// single read port with registered read data; that port sets the pace. A
// merge group first fetches its two run heads, then for each word compares
// the heads and writes the smaller one, then refills the consumed head, with
// no refill after the group's last word. A set of n words takes ceil(log2 n)
// passes. Read-out fetches each word and loads it into the output register
// when the sink is free; o_final_res marks the last word of the set. Loading
// of the next set starts as soon as the last word sits in the output
// register. Words are compared as signed at VALUE_BITS, or as unsigned at 32
// bits when VALUE_BITS exceeds 32; bits of i_value above VALUE_BITS are
// dropped and come out as zero.
module merge_sort_engine
    import mse_pkg::*;
#(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_value,
    input  wire logic               i_last,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed      [31:0] o_sorted_value,
    output logic                    o_final_res
);

    localparam int SW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int AW = $clog2(MAX_ITEMS);

    t_mem_ctl      mem;
    t_out_ctl      out_ctl;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [SW-1:0] wr_data, rd_data, elem_rd, scr_rd;
    logic          out_free;

    // output register
    logic          r_ov;
    logic [SW-1:0] r_out_value;
    logic          r_out_last;
    logic [31:0]   out_word;

    // output register can take a new word this cycle
    assign out_free = !r_ov || !i_stall;
    assign rd_data  = mem.rd_scr ? scr_rd : elem_rd;

    mse_seq #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_last  (i_last),
        .i_in_value (i_value[SW-1:0]),
        .i_rd_data  (rd_data),
        .i_out_free (out_free),
        .o_in_stall (o_stall),
        .o_mem      (mem),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_addr  (rd_addr),
        .o_out      (out_ctl)
    );

    // element memory: loaded from the input, then source/target of merges
    mse_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_ITEMS)
    ) u_elem_ram (
        .i_clk     (i_clk),
        .i_we      (mem.we_elem),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (elem_rd)
    );

    // scratch memory: the other half of the ping-pong
    mse_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_ITEMS)
    ) u_scr_ram (
        .i_clk     (i_clk),
        .i_we      (mem.we_scr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (scr_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_ctl.load) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
        if (out_ctl.load) begin
            r_out_value <= rd_data;
            r_out_last  <= out_ctl.last;
        end
    end

    // narrow words come out zero-extended
    always_comb begin
        out_word         = '0;
        out_word[SW-1:0] = r_out_value;
    end

    assign o_valid        = r_ov;
    assign o_sorted_value = out_word;
    assign o_final_res    = r_out_last;

endmodule

`default_nettype wire

// ===== src/mse_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/mse_seq.sv =====
// Load, merge-pass and read-out sequencer with the run head registers.
`default_nettype none

module mse_seq
    import mse_pkg::*;
#(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32,
    localparam int SW = (VALUE_BITS < 32) ? VALUE_BITS : 32,
    localparam int AW = $clog2(MAX_ITEMS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_last,
    input  wire logic [SW-1:0] i_in_value,
    input  wire logic [SW-1:0] i_rd_data,
    input  wire logic          i_out_free,
    output logic               o_in_stall,
    output t_mem_ctl           o_mem,
    output logic      [AW-1:0] o_wr_addr,
    output logic      [SW-1:0] o_wr_data,
    output logic      [AW-1:0] o_rd_addr,
    output t_out_ctl           o_out
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = CW + 2;
    // sign flip turns signed order into unsigned order; above 32 bits no flip
    // is applied, so the 32-bit stored words compare as unsigned values
    localparam logic [SW-1:0] FLIP = (VALUE_BITS <= 32) ? (SW'(1) << (SW - 1)) : '0;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_n, n_n;
    logic [PW-1:0] r_w, n_w;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic          r_src, n_src;
    logic          r_took_left, n_took_left;
    logic [SW-1:0] r_a, n_a;
    logic [SW-1:0] r_b, n_b;

    logic [CW-1:0] cnt_inc, i_inc, j_inc, k_inc;
    logic          ends, take_left, grp_end, more_grp, more_pass, out_last;
    logic [PW-1:0] mid_full, hi_full, lo_next, w2;

    assign cnt_inc   = r_cnt + CW'(1);
    assign ends      = i_in_last || (cnt_inc == CW'(MAX_ITEMS));
    assign i_inc     = r_i + CW'(1);
    assign j_inc     = r_j + CW'(1);
    assign k_inc     = r_k + CW'(1);
    assign w2        = r_w << 1;
    assign mid_full  = PW'(r_lo) + r_w;
    assign hi_full   = PW'(r_lo) + w2;
    assign lo_next   = PW'(r_lo) + w2;
    assign take_left = (r_i < r_mid) &&
                       ((r_j >= r_hi) || ((r_a ^ FLIP) <= (r_b ^ FLIP)));
    assign grp_end   = (k_inc == r_hi);
    assign more_grp  = (lo_next < PW'(r_n));
    assign more_pass = (w2 < PW'(r_n));
    assign out_last  = (k_inc == r_n);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid && ends) begin
                    n_state = (cnt_inc > CW'(1)) ? ST_RDA : ST_OUT_RD;
                end
            end
            ST_RDA:  n_state = ST_LDA;
            ST_LDA:  n_state = ST_LDB;
            ST_LDB:  n_state = ST_CMP;
            ST_CMP: begin
                if (!grp_end) begin
                    n_state = ST_LDN;
                end else if (more_grp || more_pass) begin
                    n_state = ST_RDA;
                end else begin
                    n_state = ST_OUT_RD;
                end
            end
            ST_LDN:  n_state = ST_CMP;
            ST_OUT_RD: begin
                if (i_out_free) begin
                    n_state = ST_OUT_LD;
                end
            end
            ST_OUT_LD: n_state = out_last ? ST_LOAD : ST_OUT_RD;
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall    = (r_state != ST_LOAD);
        o_mem.we_elem = 1'b0;
        o_mem.we_scr  = 1'b0;
        o_mem.rd_scr  = r_src;
        o_wr_addr     = r_k[AW-1:0];
        o_wr_data     = take_left ? r_a : r_b;
        o_rd_addr     = r_k[AW-1:0];
        o_out.load    = 1'b0;
        o_out.last    = out_last;
        case (r_state)
            ST_LOAD: begin
                o_mem.we_elem = i_in_valid;
                o_wr_addr     = r_cnt[AW-1:0];
                o_wr_data     = i_in_value;
            end
            ST_RDA:  o_rd_addr = r_lo[AW-1:0];
            ST_LDA:  o_rd_addr = r_j[AW-1:0];
            ST_CMP: begin
                // write into the memory that is not the source of this pass
                o_mem.we_elem = r_src;
                o_mem.we_scr  = !r_src;
                o_rd_addr     = take_left ? i_inc[AW-1:0] : j_inc[AW-1:0];
            end
            ST_OUT_LD: o_out.load = 1'b1;
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_w         = r_w;
        n_lo        = r_lo;
        n_mid       = r_mid;
        n_hi        = r_hi;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_src       = r_src;
        n_took_left = r_took_left;
        n_a         = r_a;
        n_b         = r_b;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid) begin
                    n_cnt = cnt_inc;
                    if (ends) begin
                        n_n   = cnt_inc;
                        n_cnt = '0;
                        n_src = 1'b0;
                        n_w   = PW'(1);
                        n_lo  = '0;
                        n_k   = '0;
                    end
                end
            end
            ST_RDA: begin
                n_mid = (mid_full < PW'(r_n)) ? mid_full[CW-1:0] : r_n;
                n_hi  = (hi_full < PW'(r_n)) ? hi_full[CW-1:0] : r_n;
                n_i   = r_lo;
                n_j   = (mid_full < PW'(r_n)) ? mid_full[CW-1:0] : r_n;
                n_k   = r_lo;
            end
            ST_LDA:  n_a = i_rd_data;
            ST_LDB:  n_b = i_rd_data;
            ST_CMP: begin
                n_took_left = take_left;
                n_k         = k_inc;
                if (take_left) begin
                    n_i = i_inc;
                end else begin
                    n_j = j_inc;
                end
                if (grp_end) begin
                    if (more_grp) begin
                        n_lo = lo_next[CW-1:0];
                    end else begin
                        n_src = !r_src;
                        n_lo  = '0;
                        n_w   = w2;
                        n_k   = '0;
                    end
                end
            end
            ST_LDN: begin
                if (r_took_left) begin
                    n_a = i_rd_data;
                end else begin
                    n_b = i_rd_data;
                end
            end
            ST_OUT_LD: n_k = k_inc;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_n         <= n_n;
        r_w         <= n_w;
        r_lo        <= n_lo;
        r_mid       <= n_mid;
        r_hi        <= n_hi;
        r_i         <= n_i;
        r_j         <= n_j;
        r_k         <= n_k;
        r_src       <= n_src;
        r_took_left <= n_took_left;
        r_a         <= n_a;
        r_b         <= n_b;
    end

endmodule

`default_nettype wire

// ===== src/mse_checker.sv =====
// Port-level checks for the merge sort engine, bound to the top level.
`default_nettype none

module mse_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        i_last,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_sorted_value,
    input wire logic        o_final_res
);

    // reset empties the output and opens the input
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output pending or input stalled after reset");

    // a held word does not change under stall
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sorted_value) && $stable(o_final_res))
        else $error("stalled output word changed");

    // a word marked last closes the set: input stalls while it sorts
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last |=> o_stall)
        else $error("input still open after last word");

    // no loading while a set is only partly read out
    a_no_load_midset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_final_res |-> o_stall)
        else $error("input open during read-out");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_last         (i_last),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_sorted_value (o_sorted_value),
    .o_final_res    (o_final_res)
);

`default_nettype wire
